// File: rtl/assert_macros.svh
// Assertion macros shared by the filter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is low.
`define BAFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define BAFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bafl_pkg.sv
// Package for the beacon advertisement filter: types, structure codes and limits.
// Used by the parser, the config block and the top level.
package bafl_pkg;

  localparam int unsigned MaxAdvBytes = 31;

  localparam logic [7:0] MfrType        = 8'hFF;
  localparam logic [7:0] BeaconAdLen    = 8'h1A;
  localparam logic [7:0] CompanyLo      = 8'h4C;
  localparam logic [7:0] CompanyHi      = 8'h00;
  localparam logic [7:0] BeaconKind     = 8'h02;
  localparam logic [7:0] BeaconInnerLen = 8'h15;

  localparam logic [4:0] OffCompanyLo = 5'd0;
  localparam logic [4:0] OffCompanyHi = 5'd1;
  localparam logic [4:0] OffKind      = 5'd2;
  localparam logic [4:0] OffInnerLen  = 5'd3;
  localparam logic [4:0] OffIdFirst   = 5'd4;
  localparam logic [4:0] OffMajorHi   = 5'd20;
  localparam logic [4:0] OffMajorLo   = 5'd21;
  localparam logic [4:0] OffMinorHi   = 5'd22;
  localparam logic [4:0] OffMinorLo   = 5'd23;
  localparam logic [4:0] OffPower     = 5'd24;

  localparam logic [63:0] UuidHighReset = 64'hAAAA_AAAA_BBBB_CCCC;
  localparam logic [63:0] UuidLowReset  = 64'hDDDD_EEEE_EEEE_EEEE;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [1:0] {
    VERD_NONE = 2'd0,
    VERD_OK   = 2'd1,
    VERD_BAD  = 2'd2
  } verdict_e;

  typedef enum logic {
    REG_UUID_HIGH = 1'b0,
    REG_UUID_LOW  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              last;
    logic signed [7:0] signal_dbm;
  } byte_t;

  typedef struct packed {
    logic              valid_res;
    logic [15:0]       major;
    logic [15:0]       minor;
    logic signed [7:0] cal_power;
    logic              near;
  } res_t;

endpackage

// File: rtl/bafl_if.sv
// Valid/ready channel interfaces for payload bytes and filter results.
// Depends on nothing outside this file.
interface bafl_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic              last;
  logic signed [7:0] signal_dbm;

  modport source (output valid, output data_byte, output last, output signal_dbm,
                  input ready);
  modport sink (input valid, input data_byte, input last, input signal_dbm,
                output ready);
endinterface

interface bafl_res_if;
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [15:0]       major;
  logic [15:0]       minor;
  logic signed [7:0] cal_power;
  logic              near;

  modport source (output valid, output valid_res, output major, output minor,
                  output cal_power, output near, input ready);
  modport sink (input valid, input valid_res, input major, input minor,
                input cal_power, input near, output ready);
endinterface

// File: rtl/beacon_advert_filter.sv
// Beacon advertisement filter, top level.
// Depends on bafl_pkg, bafl_if, bafl_cfg, bafl_parse and assert_macros.svh.
//
// Usage:
//   byte_i takes one payload byte per item with its last flag and the packet's
//   signal strength. res_o gives one result item per packet, after its last byte.
//   The APB port holds the 128-bit identifier: uuid_high at 0x0, uuid_low at 0x8.
//   Write it only while no packet is in flight.
// Timing:
//   An accepted byte lands in an input register; from there the parser updates
//   the packet state and, on a last byte, loads the result register.
//   Throughput, set by the single parser pass between the input and result
//   registers, is one byte per cycle save while a last byte waits on a held result.
// Reset:
//   Clears the packet state and both item valid flags, loads the default identifier.
// Stall:
//   While a result waits, non-last bytes keep flowing; a last byte waits in the
//   input register and byte_i.ready drops until the result is taken.
`include "assert_macros.svh"

module beacon_advert_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bafl_in_if.sink                       byte_i,
  bafl_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bafl_pkg::CfgAddrW-1:0] paddr,
  input  logic [bafl_pkg::CfgDataW-1:0] pwdata,
  output logic [bafl_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic            stage_valid_q, stage_valid_d;
  bafl_pkg::byte_t stage_q;
  logic            res_valid_q, res_valid_d;
  bafl_pkg::res_t  res_q;
  bafl_pkg::res_t  parse_res;
  logic [63:0]     uuid_high;
  logic [63:0]     uuid_low;
  logic            res_free;
  logic            advance;
  logic            in_acc;
  logic            last_adv;
  logic            res_stall;
  logic            res_drop;
  logic            res_blank;
  logic            all_idle;

  bafl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .uuid_high_o (uuid_high),
    .uuid_low_o  (uuid_low)
  );

  bafl_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (stage_q),
    .uuid_high_i (uuid_high),
    .uuid_low_i  (uuid_low),
    .res_o       (parse_res)
  );

  assign res_free     = !res_valid_q || res_o.ready;
  assign advance      = stage_valid_q && (!stage_q.last || res_free);
  assign byte_i.ready = !stage_valid_q || advance;
  assign in_acc       = byte_i.valid && byte_i.ready;

  always_comb begin
    stage_valid_d = in_acc || (stage_valid_q && !advance);
    res_valid_d   = res_valid_q;
    if (advance && stage_q.last) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q.data_byte  <= byte_i.data_byte;
      stage_q.last       <= byte_i.last;
      stage_q.signal_dbm <= byte_i.signal_dbm;
    end
    if (advance && stage_q.last) begin
      res_q <= parse_res;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.valid_res = res_q.valid_res;
  assign res_o.major     = res_q.major;
  assign res_o.minor     = res_q.minor;
  assign res_o.cal_power = res_q.cal_power;
  assign res_o.near      = res_q.near;

  assign last_adv  = advance && stage_q.last;
  assign res_stall = res_valid_q && !res_o.ready;
  assign res_drop  = res_valid_q && !res_q.valid_res;
  assign res_blank = res_q.major == 16'd0 && res_q.minor == 16'd0 &&
                     res_q.cal_power == 8'sd0 && !res_q.near;
  assign all_idle  = !stage_valid_q && !res_valid_q;

  `BAFL_ASSERT(a_no_overwrite, clk_i, rst_ni, res_stall |-> !last_adv, "result overwritten")
  `BAFL_ASSERT(a_empty_ready, clk_i, rst_ni, !stage_valid_q |-> byte_i.ready, "empty stage stalls")
  `BAFL_ASSERT(a_zero_fields, clk_i, rst_ni, res_drop |-> res_blank, "nonzero fields")
  `BAFL_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> all_idle, "busy in reset")

endmodule

// File: rtl/bafl_cfg.sv
// APB-style register file holding the 128-bit beacon identifier.
// Depends on bafl_pkg.
module bafl_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bafl_pkg::CfgAddrW-1:0] paddr,
  input  logic [bafl_pkg::CfgDataW-1:0] pwdata,
  output logic [bafl_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output logic [63:0]                   uuid_high_o,
  output logic [63:0]                   uuid_low_o
);

  logic [63:0]        uuid_high_q;
  logic [63:0]        uuid_low_q;
  logic               wr_en;
  bafl_pkg::cfg_reg_e sel;

  assign sel    = bafl_pkg::cfg_reg_e'(paddr[3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_high_q <= bafl_pkg::UuidHighReset;
      uuid_low_q  <= bafl_pkg::UuidLowReset;
    end else if (wr_en) begin
      case (sel)
        bafl_pkg::REG_UUID_HIGH: uuid_high_q <= pwdata;
        bafl_pkg::REG_UUID_LOW:  uuid_low_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      bafl_pkg::REG_UUID_HIGH: prdata = uuid_high_q;
      bafl_pkg::REG_UUID_LOW:  prdata = uuid_low_q;
      default:                 prdata = '0;
    endcase
  end

  assign uuid_high_o = uuid_high_q;
  assign uuid_low_o  = uuid_low_q;

endmodule

// File: rtl/bafl_parse.sv
// Packet state and single-pass structure parser; computes the result for a last byte.
// Depends on bafl_pkg.
module bafl_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  bafl_pkg::byte_t      item_i,
  input  logic [63:0]          uuid_high_i,
  input  logic [63:0]          uuid_low_i,
  output bafl_pkg::res_t       res_o
);

  logic [7:0]         byte_pos_q, byte_pos_d;
  logic [8:0]         next_pos_q, next_pos_d;
  logic               in_beacon_q, in_beacon_d;
  logic [4:0]         off_q, off_d;
  bafl_pkg::verdict_e verdict_q, verdict_d;
  logic [7:0]         pending_len_q, pending_len_d;
  logic [15:0]        major_q, major_d;
  logic [15:0]        minor_q, minor_d;
  logic [7:0]         power_q, power_d;

  logic [127:0]       uuid_all;
  logic [7:0]         id_bytes [16];
  logic [3:0]         id_idx;
  logic [7:0]         b;
  logic               ok;
  logic               valid;

  assign uuid_all = {uuid_high_i, uuid_low_i};
  assign b        = item_i.data_byte;
  assign id_idx   = 4'(off_q - bafl_pkg::OffIdFirst);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      id_bytes[i] = uuid_all[127 - 8 * i -: 8];
    end
  end

  always_comb begin
    byte_pos_d    = byte_pos_q;
    next_pos_d    = next_pos_q;
    in_beacon_d   = in_beacon_q;
    off_d         = off_q;
    verdict_d     = verdict_q;
    pending_len_d = pending_len_q;
    major_d       = major_q;
    minor_d       = minor_q;
    power_d       = power_q;
    ok            = 1'b1;

    if (byte_pos_q < 8'(bafl_pkg::MaxAdvBytes) && verdict_q == bafl_pkg::VERD_NONE) begin
      if (in_beacon_q) begin
        if (off_q == bafl_pkg::OffCompanyLo) begin
          ok = (b == bafl_pkg::CompanyLo);
        end else if (off_q == bafl_pkg::OffCompanyHi) begin
          ok = (b == bafl_pkg::CompanyHi);
        end else if (off_q == bafl_pkg::OffKind) begin
          ok = (b == bafl_pkg::BeaconKind);
        end else if (off_q == bafl_pkg::OffInnerLen) begin
          ok = (b == bafl_pkg::BeaconInnerLen);
        end else if (off_q < bafl_pkg::OffMajorHi) begin
          ok = (b == id_bytes[id_idx]);
        end else if (off_q == bafl_pkg::OffMajorHi) begin
          major_d[15:8] = b;
        end else if (off_q == bafl_pkg::OffMajorLo) begin
          major_d[7:0] = b;
        end else if (off_q == bafl_pkg::OffMinorHi) begin
          minor_d[15:8] = b;
        end else if (off_q == bafl_pkg::OffMinorLo) begin
          minor_d[7:0] = b;
        end else begin
          power_d = b;
        end

        if (!ok) begin
          verdict_d   = bafl_pkg::VERD_BAD;
          in_beacon_d = 1'b0;
        end else if (off_q >= bafl_pkg::OffPower) begin
          verdict_d   = bafl_pkg::VERD_OK;
          in_beacon_d = 1'b0;
        end else begin
          off_d = off_q + 5'd1;
        end
      end else if ({1'b0, byte_pos_q} == next_pos_q) begin
        pending_len_d = b;
        next_pos_d    = {1'b0, byte_pos_q} + {1'b0, b} + 9'd1;
      end else if (pending_len_q == bafl_pkg::BeaconAdLen &&
                   {1'b0, byte_pos_q} + {1'b0, bafl_pkg::BeaconAdLen} == next_pos_q &&
                   b == bafl_pkg::MfrType) begin
        in_beacon_d = 1'b1;
        off_d       = '0;
      end
    end

    if (byte_pos_q != 8'hFF) begin
      byte_pos_d = byte_pos_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q    <= '0;
      next_pos_q    <= '0;
      in_beacon_q   <= 1'b0;
      off_q         <= '0;
      verdict_q     <= bafl_pkg::VERD_NONE;
      pending_len_q <= '0;
      major_q       <= '0;
      minor_q       <= '0;
      power_q       <= '0;
    end else if (step_i) begin
      if (item_i.last) begin
        byte_pos_q    <= '0;
        next_pos_q    <= '0;
        in_beacon_q   <= 1'b0;
        off_q         <= '0;
        verdict_q     <= bafl_pkg::VERD_NONE;
        pending_len_q <= '0;
        major_q       <= '0;
        minor_q       <= '0;
        power_q       <= '0;
      end else begin
        byte_pos_q    <= byte_pos_d;
        next_pos_q    <= next_pos_d;
        in_beacon_q   <= in_beacon_d;
        off_q         <= off_d;
        verdict_q     <= verdict_d;
        pending_len_q <= pending_len_d;
        major_q       <= major_d;
        minor_q       <= minor_d;
        power_q       <= power_d;
      end
    end
  end

  assign valid = (verdict_d == bafl_pkg::VERD_OK);

  always_comb begin
    res_o.valid_res = valid;
    res_o.major     = valid ? major_d : 16'd0;
    res_o.minor     = valid ? minor_d : 16'd0;
    res_o.cal_power = valid ? $signed(power_d) : 8'sd0;
    res_o.near      = valid && (item_i.signal_dbm > $signed(power_d));
  end

endmodule
